// ----- rtl/core/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the circular deque: request codes, status codes,
// sequencer states and the marker shown for an empty end.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 7;
    localparam int SIZE_W  = 7;

    localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK       = 3'd4
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

endpackage

// ----- rtl/core/cdq_slot_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_slot_ram
// Slot storage of the deque: one write port, one read port, registered reads.
// ----------------------------------------------------------------------------
module cdq_slot_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]          o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/circular_deque_top.sv -----
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of 32-bit elements in a circular slot memory.
// ----------------------------------------------------------------------------
// Each request pushes at the front or rear, pops from the front or rear, or
// peeks, and gives one result with status, popped element, front and rear
// elements and entry count. The front and rear elements are kept in registers
// beside the slot memory, so a push, a peek, a refused request and a pop of
// the last element are answered in the next cycle; a pop that leaves elements
// behind passes through S_LOAD, as the new end element comes from the memory's
// registered read port. A new request is taken outside S_LOAD once the result
// register is free or being drained. Writing the size empties the deque (slot
// contents stay); size 0 acts as 1, above DEPTH as DEPTH. The block leaves it
// to the user to see the size is written only while no request is in flight.
// ----------------------------------------------------------------------------
module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    // requests
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic [TOTAL_W-1:0]   o_entry_total
);

    localparam int IW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int SW       = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int RST_SIZE = (DEPTH < 64) ? DEPTH : 64;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_front_idx, n_front_idx;
    logic [IW-1:0]     r_rear_idx, n_rear_idx;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_front_val, n_front_val;
    logic [DATA_W-1:0] r_rear_val, n_rear_val;
    logic [CW-1:0]     r_size;
    logic [IW-1:0]     r_last;
    logic              r_load_front, n_load_front;

    logic              r_out_valid;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_popped, n_out_popped;
    logic [DATA_W-1:0] r_out_front, n_out_front;
    logic [DATA_W-1:0] r_out_rear, n_out_rear;
    logic [TOTAL_W-1:0] r_out_total;

    logic              in_acc;
    logic              cfg_acc;
    logic              wait_load;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [SW-1:0]     cfg_ext;
    logic [SW-1:0]     size_cl;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx,
                                              input logic [IW-1:0] last);
        return (idx == last) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] idx,
                                              input logic [IW-1:0] last);
        return (idx == '0) ? last : idx - IW'(1);
    endfunction

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && wait_load) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = !r_out_valid || i_out_ready;
                o_cfg_ready = 1'b1;
            end
            S_LOAD: begin
                o_in_ready  = 1'b0;
                o_cfg_ready = 1'b0;
            end
            default: begin
                o_in_ready  = 1'b0;
                o_cfg_ready = 1'b0;
            end
        endcase
    end

    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // clamp of the written size to 1..DEPTH
    always_comb begin
        cfg_ext = SW'(i_cfg_data);
        if (cfg_ext == '0) begin
            size_cl = SW'(1);
        end else if (cfg_ext > SW'(DEPTH)) begin
            size_cl = SW'(DEPTH);
        end else begin
            size_cl = cfg_ext;
        end
    end

    // ---- request datapath ----
    always_comb begin
        n_front_idx  = r_front_idx;
        n_rear_idx   = r_rear_idx;
        n_count      = r_count;
        n_front_val  = r_front_val;
        n_rear_val   = r_rear_val;
        n_load_front = r_load_front;
        n_out_status = ST_OK;
        n_out_popped = '0;
        wait_load    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (t_req'(i_req_type))
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (r_count >= r_size) begin
                    n_out_status = ST_FULL;
                end else begin
                    wr_en   = in_acc;
                    n_count = r_count + CW'(1);
                    if (r_count == '0) begin
                        n_front_idx = '0;
                        n_rear_idx  = '0;
                        wr_addr     = '0;
                        n_front_val = i_push_value;
                        n_rear_val  = i_push_value;
                    end else if (t_req'(i_req_type) == REQ_PUSH_FRONT) begin
                        n_front_idx = idx_dec(r_front_idx, r_last);
                        wr_addr     = n_front_idx;
                        n_front_val = i_push_value;
                    end else begin
                        n_rear_idx = idx_inc(r_rear_idx, r_last);
                        wr_addr    = n_rear_idx;
                        n_rear_val = i_push_value;
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (r_count == '0) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_count      = r_count - CW'(1);
                    n_out_popped = (t_req'(i_req_type) == REQ_POP_FRONT) ?
                                   r_front_val : r_rear_val;
                    if (r_count == CW'(1)) begin
                        n_front_idx = '0;
                        n_rear_idx  = '0;
                    end else begin
                        // new end element comes from the slot memory
                        wait_load = 1'b1;
                        rd_en     = in_acc;
                        if (t_req'(i_req_type) == REQ_POP_FRONT) begin
                            n_front_idx  = idx_inc(r_front_idx, r_last);
                            rd_addr      = n_front_idx;
                            n_load_front = 1'b1;
                        end else begin
                            n_rear_idx   = idx_dec(r_rear_idx, r_last);
                            rd_addr      = n_rear_idx;
                            n_load_front = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase

        n_out_front = (n_count == '0) ? EMPTY_MARK : n_front_val;
        n_out_rear  = (n_count == '0) ? EMPTY_MARK : n_rear_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front_idx  <= '0;
            r_rear_idx   <= '0;
            r_count      <= '0;
            r_size       <= CW'(RST_SIZE);
            r_last       <= IW'(RST_SIZE - 1);
            r_load_front <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_front_idx <= '0;
                r_rear_idx  <= '0;
                r_count     <= '0;
                r_size      <= CW'(size_cl);
                r_last      <= IW'(size_cl - SW'(1));
            end else if (in_acc) begin
                r_front_idx  <= n_front_idx;
                r_rear_idx   <= n_rear_idx;
                r_count      <= n_count;
                r_load_front <= n_load_front;
            end

            if (in_acc) begin
                r_out_valid <= !wait_load;
            end else if (r_state == S_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, end-element caches and result fields
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_front_val  <= n_front_val;
            r_rear_val   <= n_rear_val;
            r_out_status <= n_out_status;
            r_out_popped <= n_out_popped;
            r_out_front  <= n_out_front;
            r_out_rear   <= n_out_rear;
            r_out_total  <= TOTAL_W'(n_count);
        end else if (r_state == S_LOAD) begin
            if (r_load_front) begin
                r_front_val <= rd_data;
                r_out_front <= rd_data;
            end else begin
                r_rear_val <= rd_data;
                r_out_rear <= rd_data;
            end
        end
    end

    cdq_slot_ram #(
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = STAT_W'(r_out_status);
    assign o_popped_value = r_out_popped;
    assign o_front_value  = r_out_front;
    assign o_rear_value   = r_out_rear;
    assign o_entry_total  = r_out_total;

endmodule

// ----- rtl/core/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque results, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_out_valid,
    input  logic [STAT_W-1:0]        o_status,
    input  logic signed [DATA_W-1:0] o_popped_value,
    input  logic signed [DATA_W-1:0] o_front_value,
    input  logic signed [DATA_W-1:0] o_rear_value,
    input  logic [TOTAL_W-1:0]       o_entry_total
);

    // a refused pop only happens on an empty deque and removes nothing
    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
            o_entry_total == '0 && o_popped_value == '0)
        else $error("empty refusal with entries or popped data");

    // both ends show the marker when nothing is held
    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_total == '0 |->
            o_front_value == EMPTY_MARK && o_rear_value == EMPTY_MARK)
        else $error("empty deque without end markers");

    // a single element is both the front and the rear
    a_single_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_total == TOTAL_W'(1) |->
            o_front_value == o_rear_value)
        else $error("single element with different ends");

    // a refused push means the deque holds something
    a_full_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entry_total != '0)
        else $error("full refusal with empty deque");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .o_status       (o_status),
    .o_popped_value (o_popped_value),
    .o_front_value  (o_front_value),
    .o_rear_value   (o_rear_value),
    .o_entry_total  (o_entry_total)
);
